// File: rtl/core/particle_drag_gravity_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle step block
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_DRAG_GRAVITY_STEP_ASSERT_SVH
`define PARTICLE_DRAG_GRAVITY_STEP_ASSERT_SVH

// Same-cycle implication.
`define PDG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PDG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pdg_pkg.sv
// ----------------------------------------------------------------------------
// pdg_pkg
// Shared codes, command and status types for the particle step block.
// ----------------------------------------------------------------------------
package pdg_pkg;

   // Item function codes
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_LAUNCH = 1'b1;

   // Register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AIR_FRICTION = 1'b1;

   // One result bit per square root step
   localparam int unsigned SQRT_STEPS = 32;

   // Datapath operations, one per cycle
   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_XX     = 4'd1,
      OP_YY     = 4'd2,
      OP_XD     = 4'd3,
      OP_YD     = 4'd4,
      OP_PDY    = 4'd5,
      OP_SQRT   = 4'd6,
      OP_FN     = 4'd7,
      OP_CAPK   = 4'd8,
      OP_KXL    = 4'd9,
      OP_KXH    = 4'd10,
      OP_KYL    = 4'd11,
      OP_KYH    = 4'd12,
      OP_DY     = 4'd13,
      OP_COMMIT = 4'd14
   } dp_op_type;

   typedef struct packed {
      logic      load_launch;
      logic      load_tick;
      dp_op_type op;
      logic      rsp_load;
   } pdg_cmd_type;

   typedef struct packed {
      logic active;
   } pdg_sts_type;

endpackage

// File: rtl/core/pdg_if.sv
// ----------------------------------------------------------------------------
// pdg_if
// Valid/ready channels of the particle step block: items, results, registers.
// ----------------------------------------------------------------------------
interface pdg_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic        [15:0] step_time;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] start_vx;
   logic signed [31:0] start_vy;
   logic        [23:0] life_time;

   modport source (output valid, func, step_time, start_x, start_y, start_vx, start_vy,
                   life_time, input ready);
   modport sink (input valid, func, step_time, start_x, start_y, start_vx, start_vy,
                 life_time, output ready);
endinterface

interface pdg_rsp_if;
   logic               valid;
   logic               ready;
   logic               alive;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;

   modport source (output valid, alive, pos_x, pos_y, vel_x, vel_y, input ready);
   modport sink (input valid, alive, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface pdg_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/particle_drag_gravity_step.sv
// ----------------------------------------------------------------------------
// particle_drag_gravity_step
// One particle integrated by explicit Euler steps with quadratic drag.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  takes one item per handshake: a launch (func 1) loads position,
//             velocity and life limit; a tick (func 0) advances by step_time.
//   rsp_chan  gives exactly one result per item: alive flag, position and
//             velocity after that item.
//   csr_chan  writes gravity (index 0) or air_friction (index 1); always ready.
// Sequence: a launch or a tick on a dead particle goes straight to the result
//   state after acceptance; a tick on a live particle first runs the
//   32-step square root of the speed and nine passes through the single
//   registered 32x32 multiplier.
// Flow: one item at a time; the next item can be taken in the same cycle
//   that the result appears in the output register.
// Reset clears the registers and the particle to zero, dead.
// A stalled receiver holds the result in the output register; one further
//   item is still taken and worked, then waits for the register to free.
// ----------------------------------------------------------------------------
module particle_drag_gravity_step (
   input logic      clock,
   input logic      reset,
   pdg_req_if.sink   req_chan,
   pdg_rsp_if.source rsp_chan,
   pdg_csr_if.sink   csr_chan
);
   import pdg_pkg::*;

   pdg_cmd_type cmd;
   pdg_sts_type sts;
   logic        csr_we;

   assign csr_chan.ready = 1'b1;
   assign csr_we         = csr_chan.valid & csr_chan.ready;

   pdg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pdg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .step_time (req_chan.step_time),
      .start_x   (req_chan.start_x),
      .start_y   (req_chan.start_y),
      .start_vx  (req_chan.start_vx),
      .start_vy  (req_chan.start_vy),
      .life_time (req_chan.life_time),
      .csr_we    (csr_we),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .rsp_alive (rsp_chan.alive),
      .rsp_pos_x (rsp_chan.pos_x),
      .rsp_pos_y (rsp_chan.pos_y),
      .rsp_vel_x (rsp_chan.vel_x),
      .rsp_vel_y (rsp_chan.vel_y)
   );

endmodule

// File: rtl/core/pdg_ctrl.sv
// ----------------------------------------------------------------------------
// pdg_ctrl
// Sequencer: walks a live tick through multiplies, square root and commit.
// ----------------------------------------------------------------------------
module pdg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pdg_pkg::pdg_sts_type sts,
   output pdg_pkg::pdg_cmd_type cmd
);
   import pdg_pkg::*;

   localparam int unsigned CNT_W = $clog2(SQRT_STEPS);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

   typedef enum logic [15:0] {
      S_IDLE   = 16'b0000_0000_0000_0001,
      S_XX     = 16'b0000_0000_0000_0010,
      S_YY     = 16'b0000_0000_0000_0100,
      S_XD     = 16'b0000_0000_0000_1000,
      S_YD     = 16'b0000_0000_0001_0000,
      S_PDY    = 16'b0000_0000_0010_0000,
      S_SQRT   = 16'b0000_0000_0100_0000,
      S_FN     = 16'b0000_0000_1000_0000,
      S_CAPK   = 16'b0000_0001_0000_0000,
      S_KXL    = 16'b0000_0010_0000_0000,
      S_KXH    = 16'b0000_0100_0000_0000,
      S_KYL    = 16'b0000_1000_0000_0000,
      S_KYH    = 16'b0001_0000_0000_0000,
      S_DY     = 16'b0010_0000_0000_0000,
      S_COMMIT = 16'b0100_0000_0000_0000,
      S_RESP   = 16'b1000_0000_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             rsp_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      cmd.load_launch = accept & (req_func == FUNC_LAUNCH);
      cmd.load_tick   = accept & (req_func == FUNC_TICK);
      cmd.op          = OP_NONE;
      cmd.rsp_load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // launch and a tick on a dead particle answer at once
               if ((req_func == FUNC_LAUNCH) || !sts.active) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_XX;
               end
            end
         end
         S_XX: begin
            cmd.op   = OP_XX;
            state_in = S_YY;
         end
         S_YY: begin
            cmd.op   = OP_YY;
            state_in = S_XD;
         end
         S_XD: begin
            cmd.op   = OP_XD;
            state_in = S_YD;
         end
         S_YD: begin
            cmd.op   = OP_YD;
            state_in = S_PDY;
         end
         S_PDY: begin
            cmd.op   = OP_PDY;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = S_FN;
            end
         end
         S_FN: begin
            cmd.op   = OP_FN;
            state_in = S_CAPK;
         end
         S_CAPK: begin
            cmd.op   = OP_CAPK;
            state_in = S_KXL;
         end
         S_KXL: begin
            cmd.op   = OP_KXL;
            state_in = S_KXH;
         end
         S_KXH: begin
            cmd.op   = OP_KXH;
            state_in = S_KYL;
         end
         S_KYL: begin
            cmd.op   = OP_KYL;
            state_in = S_KYH;
         end
         S_KYH: begin
            cmd.op   = OP_KYH;
            state_in = S_DY;
         end
         S_DY: begin
            cmd.op   = OP_DY;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/pdg_datapath.sv
// ----------------------------------------------------------------------------
// pdg_datapath
// Particle state, registers, one shared 32x32 multiplier and a square root.
// ----------------------------------------------------------------------------
module pdg_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  pdg_pkg::pdg_cmd_type             cmd,
   output pdg_pkg::pdg_sts_type             sts,
   input  logic                      [15:0] step_time,
   input  logic signed               [31:0] start_x,
   input  logic signed               [31:0] start_y,
   input  logic signed               [31:0] start_vx,
   input  logic signed               [31:0] start_vy,
   input  logic                      [23:0] life_time,
   input  logic                             csr_we,
   input  logic [pdg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic                      [31:0] csr_data,
   output logic                             rsp_alive,
   output logic signed               [31:0] rsp_pos_x,
   output logic signed               [31:0] rsp_pos_y,
   output logic signed               [31:0] rsp_vel_x,
   output logic signed               [31:0] rsp_vel_y
);
   import pdg_pkg::*;

   localparam logic [34:0] DRAG_CAP = 35'h4_0000_0000;
   localparam logic [31:0] S32_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN  = 32'h8000_0000;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [31:0] sat34(input logic [33:0] v);
      if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
         return v[31:0];
      end
      return v[33] ? S32_MIN : S32_MAX;
   endfunction

   function automatic logic [31:0] sat37(input logic [36:0] v);
      if ((v[36:31] == 6'b000000) || (v[36:31] == 6'b111111)) begin
         return v[31:0];
      end
      return v[36] ? S32_MIN : S32_MAX;
   endfunction

   function automatic logic [34:0] drag_cap(input logic [71:0] full);
      logic [55:0] p;
      p = full[71:16];
      if (p > {21'b0, DRAG_CAP}) begin
         return DRAG_CAP;
      end
      return p[34:0];
   endfunction

   // registers
   logic [31:0] gravity_ff, gravity_in;
   logic [23:0] friction_ff, friction_in;

   // particle state
   logic        active_ff, active_in;
   logic [23:0] age_ff, age_in;
   logic [23:0] limit_ff, limit_in;
   logic [31:0] pos_x_ff, pos_x_in;
   logic [31:0] pos_y_ff, pos_y_in;
   logic [31:0] vel_x_ff, vel_x_in;
   logic [31:0] vel_y_ff, vel_y_in;

   // working registers
   logic [15:0] dt_ff, dt_in;
   logic [31:0] mx_ff, mx_in;
   logic [31:0] my_ff, my_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [39:0] k_ff, k_in;
   logic [31:0] pdx_ff, pdx_in;
   logic [31:0] pdy_ff, pdy_in;
   logic [34:0] dx_ff, dx_in;
   logic [34:0] dy_ff, dy_in;

   // result register
   logic        rsp_alive_ff;
   logic [31:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_vel_x_ff, rsp_vel_y_ff;

   logic [31:0] mul_a, mul_b;
   logic [35:0] sq_rem_sh, sq_trial;
   logic        sq_fit;
   logic [71:0] drag_full;
   logic        age_over;
   logic [24:0] age_sum;
   logic [33:0] pdx_term, pdy_term;
   logic [36:0] dx_term, dy_term;
   logic [36:0] vx_sum, vy_sum;

   assign sts.active = active_ff;

   // ---------------------------------------------------------------- csr
   always_comb begin
      gravity_in  = gravity_ff;
      friction_in = friction_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GRAVITY:      gravity_in  = csr_data;
            CSR_AIR_FRICTION: friction_in = csr_data[23:0];
         endcase
      end
   end

   // ---------------------------------------------------------- multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_XX: begin
            mul_a = mx_ff;
            mul_b = mx_ff;
         end
         OP_YY: begin
            mul_a = my_ff;
            mul_b = my_ff;
         end
         OP_XD: begin
            mul_a = mx_ff;
            mul_b = {16'b0, dt_ff};
         end
         OP_YD: begin
            mul_a = my_ff;
            mul_b = {16'b0, dt_ff};
         end
         OP_FN: begin
            mul_a = {8'b0, friction_ff};
            mul_b = root_ff;
         end
         OP_KXL: begin
            mul_a = k_ff[31:0];
            mul_b = mx_ff;
         end
         OP_KXH: begin
            mul_a = {24'b0, k_ff[39:32]};
            mul_b = mx_ff;
         end
         OP_KYL: begin
            mul_a = k_ff[31:0];
            mul_b = my_ff;
         end
         OP_KYH: begin
            mul_a = {24'b0, k_ff[39:32]};
            mul_b = my_ff;
         end
         default: ;
      endcase
   end

   assign prod_in = {32'b0, mul_a} * {32'b0, mul_b};

   // ---------------------------------------------------------- square root
   // one result bit per cycle: shift in two radicand bits, try to subtract
   assign sq_rem_sh = {rem_ff, acc_ff[63:62]};
   assign sq_trial  = {2'b00, root_ff, 2'b01};
   assign sq_fit    = (sq_rem_sh >= sq_trial);

   // low partial from acc, high partial of the drag product from the multiplier
   assign drag_full = {8'b0, acc_ff} + {prod_ff[39:0], 32'b0};

   always_comb begin
      dt_in   = dt_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      k_in    = k_ff;
      pdx_in  = pdx_ff;
      pdy_in  = pdy_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      if (cmd.load_tick) begin
         dt_in = step_time;
         mx_in = mag32(vel_x_ff);
         my_in = mag32(vel_y_ff);
      end
      unique case (cmd.op)
         OP_YY:   acc_in = prod_ff;
         OP_XD:   acc_in = acc_ff + prod_ff;
         OP_YD:   pdx_in = prod_ff[47:16];
         OP_PDY: begin
            pdy_in  = prod_ff[47:16];
            rem_in  = '0;
            root_in = '0;
         end
         OP_SQRT: begin
            acc_in  = {acc_ff[61:0], 2'b00};
            rem_in  = sq_fit ? 34'(sq_rem_sh - sq_trial) : sq_rem_sh[33:0];
            root_in = {root_ff[30:0], sq_fit};
         end
         OP_CAPK: k_in   = prod_ff[55:16];
         OP_KXH:  acc_in = prod_ff;
         OP_KYL:  dx_in  = drag_cap(drag_full);
         OP_KYH:  acc_in = prod_ff;
         OP_DY:   dy_in  = drag_cap(drag_full);
         default: ;
      endcase
   end

   // --------------------------------------------------------------- commit
   assign age_over = (age_ff > limit_ff);
   assign age_sum  = (age_over ? 25'd0 : {1'b0, age_ff}) + {9'b0, dt_ff};

   assign pdx_term = vel_x_ff[31] ? (~{2'b00, pdx_ff} + 34'd1) : {2'b00, pdx_ff};
   assign pdy_term = vel_y_ff[31] ? (~{2'b00, pdy_ff} + 34'd1) : {2'b00, pdy_ff};

   // drag always pulls towards zero
   assign dx_term = vel_x_ff[31] ? {2'b00, dx_ff} : (~{2'b00, dx_ff} + 37'd1);
   assign dy_term = vel_y_ff[31] ? {2'b00, dy_ff} : (~{2'b00, dy_ff} + 37'd1);

   assign vx_sum = {{5{vel_x_ff[31]}}, vel_x_ff} + dx_term;
   assign vy_sum = {{5{vel_y_ff[31]}}, vel_y_ff} + dy_term
                 + {{5{gravity_ff[31]}}, gravity_ff};

   always_comb begin
      active_in = active_ff;
      age_in    = age_ff;
      limit_in  = limit_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      vel_x_in  = vel_x_ff;
      vel_y_in  = vel_y_ff;
      if (cmd.load_launch) begin
         active_in = 1'b1;
         age_in    = '0;
         limit_in  = life_time;
         pos_x_in  = start_x;
         pos_y_in  = start_y;
         vel_x_in  = start_vx;
         vel_y_in  = start_vy;
      end else if (cmd.op == OP_COMMIT) begin
         // the tick that finds the age past its limit kills but still moves
         if (age_over) begin
            active_in = 1'b0;
         end
         age_in   = age_sum[24] ? '1 : age_sum[23:0];
         pos_x_in = sat34({{2{pos_x_ff[31]}}, pos_x_ff} + pdx_term);
         pos_y_in = sat34({{2{pos_y_ff[31]}}, pos_y_ff} + pdy_term);
         vel_x_in = sat37(vx_sum);
         vel_y_in = sat37(vy_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff  <= '0;
         friction_ff <= '0;
         active_ff   <= 1'b0;
         age_ff      <= '0;
         limit_ff    <= '0;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         vel_x_ff    <= '0;
         vel_y_ff    <= '0;
      end else begin
         gravity_ff  <= gravity_in;
         friction_ff <= friction_in;
         active_ff   <= active_in;
         age_ff      <= age_in;
         limit_ff    <= limit_in;
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         vel_x_ff    <= vel_x_in;
         vel_y_ff    <= vel_y_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff   <= dt_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      k_ff    <= k_in;
      pdx_ff  <= pdx_in;
      pdy_ff  <= pdy_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      if (cmd.rsp_load) begin
         rsp_alive_ff <= active_ff;
         rsp_pos_x_ff <= pos_x_ff;
         rsp_pos_y_ff <= pos_y_ff;
         rsp_vel_x_ff <= vel_x_ff;
         rsp_vel_y_ff <= vel_y_ff;
      end
   end

   assign rsp_alive = rsp_alive_ff;
   assign rsp_pos_x = rsp_pos_x_ff;
   assign rsp_pos_y = rsp_pos_y_ff;
   assign rsp_vel_x = rsp_vel_x_ff;
   assign rsp_vel_y = rsp_vel_y_ff;

endmodule

// File: rtl/core/pdg_checker.sv
// ----------------------------------------------------------------------------
// pdg_checker
// Port-level checks on the particle step block, bound to the top level.
// ----------------------------------------------------------------------------
`include "particle_drag_gravity_step_assert.svh"

module pdg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_func,
   input logic signed [31:0] req_start_x,
   input logic signed [31:0] req_start_vy,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_alive,
   input logic signed [31:0] rsp_pos_x,
   input logic signed [31:0] rsp_pos_y,
   input logic signed [31:0] rsp_vel_x,
   input logic signed [31:0] rsp_vel_y
);
   import pdg_pkg::*;

   logic req_acc;
   logic launch_free;

   assign req_acc     = req_valid & req_ready;
   assign launch_free = req_acc & (req_func == FUNC_LAUNCH) & ~rsp_valid;

   // one item in work at a time
   `PDG_ASSERT_NEXT(a_one_in_flight, clock, reset, req_acc, !req_ready, "item taken while busy")

   // a launch into a free output shows the loaded particle after the response state and the result register
   `PDG_ASSERT_NEXT(a_launch_result, clock, reset, launch_free, ##1 (rsp_valid && rsp_alive && rsp_pos_x == $past(req_start_x, 2) && rsp_vel_y == $past(req_start_vy, 2)), "launch result wrong")

   // a fresh result finds the block ready for the next item
   `PDG_ASSERT_SAME(a_ready_on_result, clock, reset, $rose(rsp_valid), req_ready, "not ready when result appears")

   // stalled result holds
   `PDG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_alive) && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_vel_x) && $stable(rsp_vel_y), "stalled result changed")

endmodule

bind particle_drag_gravity_step pdg_checker u_pdg_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_func     (req_chan.func),
   .req_start_x  (req_chan.start_x),
   .req_start_vy (req_chan.start_vy),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_alive    (rsp_chan.alive),
   .rsp_pos_x    (rsp_chan.pos_x),
   .rsp_pos_y    (rsp_chan.pos_y),
   .rsp_vel_x    (rsp_chan.vel_x),
   .rsp_vel_y    (rsp_chan.vel_y)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives launch and tick items into the particle step block under changing
// gravity and drag settings, predicts results from an in-bench particle model
// or the directed table and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import pdg_pkg::*;

   localparam int DIR_ROWS       = 21;
   localparam int PHASES         = 8;
   localparam int RANDOM_ITEMS   = 1730;
   localparam int AGE_RUN_PHASE  = 1;
   localparam int TAIL_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_REPORTS    = 40;

   typedef struct packed {
      logic               func;
      logic        [15:0] step_time;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_vx;
      logic signed [31:0] start_vy;
      logic        [23:0] life_time;
   } particle_cmd_type;

   typedef struct packed {
      logic               alive;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } particle_state_type;

   typedef struct packed {
      logic signed [31:0] grav;
      logic        [23:0] fric;
   } force_cfg_type;

   typedef struct {
      int                 cfg;
      particle_cmd_type   cmd;
      bit                 typed;
      particle_state_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   pdg_req_if req_if ();
   pdg_rsp_if rsp_if ();
   pdg_csr_if csr_if ();

   particle_drag_gravity_step u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #4 clock = ~clock;

   // Particle as the bench sees it, plus the force settings
   logic               pt_alive = 1'b0;
   logic        [23:0] pt_age   = '0;
   logic        [23:0] pt_life  = '0;
   logic signed [31:0] pt_px    = '0;
   logic signed [31:0] pt_py    = '0;
   logic signed [31:0] pt_vx    = '0;
   logic signed [31:0] pt_vy    = '0;
   logic signed [31:0] g_accel  = '0;
   logic        [23:0] drag_coef = '0;

   particle_state_type states_due [$];
   int                 errors = 0;
   int                 idle_cycles = 0;
   int unsigned        burst_left = 0;
   logic               cmd_typed;
   particle_state_type cmd_want;

   localparam logic signed [31:0] CORNER_VALS [4] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF
   };

   force_cfg_type dir_forces [3] = '{
      '{32'shFFF6_3333, 24'h00_4000},
      '{32'sh7FFF_FFFF, 24'hFF_FFFF},
      '{32'sh8000_0000, 24'h00_0000}
   };

   directed_row_type dir_rows [DIR_ROWS] = '{
      '{-1, '{FUNC_TICK, 16'hFFFF, 0, 0, 0, 0, 24'h0}, 1'b1, '0},
      '{-1, '{FUNC_LAUNCH, 16'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 24'hFF_FFFF},
        1'b1, '{1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000}},
      '{-1, '{FUNC_TICK, 16'hFFFF, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{-1, '{FUNC_TICK, 16'h0000, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{-1, '{FUNC_LAUNCH, 16'h0, 0, 0, 32'sh0001_0000, 32'shFFFE_8000, 24'h0},
        1'b1, '{1'b1, 0, 0, 32'sh0001_0000, 32'shFFFE_8000}},
      '{-1, '{FUNC_TICK, 16'h8000, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{-1, '{FUNC_TICK, 16'h8000, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{-1, '{FUNC_TICK, 16'hFFFF, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{-1, '{FUNC_LAUNCH, 16'h0, 32'sh0005_0000, 32'shFFFB_0000, 32'shFFFF_0000,
              32'sh0002_0000, 24'hFF_FFFF},
        1'b1, '{1'b1, 32'sh0005_0000, 32'shFFFB_0000, 32'shFFFF_0000, 32'sh0002_0000}},
      '{-1, '{FUNC_LAUNCH, 16'h0, 32'sh1234_5678, 32'shEDCB_A988, 32'sh0000_0001,
              32'shFFFF_FFFF, 24'h00_ABCD},
        1'b1, '{1'b1, 32'sh1234_5678, 32'shEDCB_A988, 32'sh0000_0001, 32'shFFFF_FFFF}},
      '{-1, '{FUNC_TICK, 16'h0001, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{0, '{FUNC_LAUNCH, 16'h0, 32'sh0010_0000, 0, 32'sh0005_0000, 32'sh0008_0000,
             24'h03_0000},
        1'b1, '{1'b1, 32'sh0010_0000, 0, 32'sh0005_0000, 32'sh0008_0000}},
      '{-1, '{FUNC_TICK, 16'h1111, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{-1, '{FUNC_TICK, 16'h0000, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{1, '{FUNC_LAUNCH, 16'h0, 0, 0, 32'shC000_0000, 32'sh4000_0000, 24'hFF_FFFF},
        1'b1, '{1'b1, 0, 0, 32'shC000_0000, 32'sh4000_0000}},
      '{-1, '{FUNC_TICK, 16'h0100, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{-1, '{FUNC_TICK, 16'hFFFF, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{2, '{FUNC_LAUNCH, 16'h0, 0, 0, 0, 32'sh8000_0000, 24'h01_0000},
        1'b1, '{1'b1, 0, 0, 0, 32'sh8000_0000}},
      '{-1, '{FUNC_TICK, 16'hFFFF, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{-1, '{FUNC_TICK, 16'hFFFF, 0, 0, 0, 0, 24'h0}, 1'b0, '0},
      '{-1, '{FUNC_TICK, 16'hFFFF, 0, 0, 0, 0, 24'h0}, 1'b0, '0}
   };

   // ------------------------------------------------------------------------
   // Fixed-point helpers for the particle prediction
   // ------------------------------------------------------------------------
   function automatic logic signed [31:0] clamp_s32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned abs64(input longint v);
      if (v < 0) return -v;
      return v;
   endfunction

   // truncate the magnitude, then restore the sign
   function automatic longint step_offset(input longint v, input logic [15:0] dt);
      longint unsigned p;
      p = (abs64(v) * dt) >> 16;
      return (v < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint drag_term(input longint unsigned k, input longint unsigned m);
      logic [127:0] prod;
      prod = ({64'd0, k} * {64'd0, m}) >> 16;
      if (prod > (128'd1 << 34)) return longint'(64'd1 << 34);
      return longint'(prod[63:0]);
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned x);
      longint unsigned res;
      longint unsigned probe;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= res + probe) begin
            x   = x - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   function automatic particle_state_type step_particle(input particle_cmd_type c);
      longint          vx;
      longint          vy;
      longint          dx;
      longint          dy;
      longint unsigned mx;
      longint unsigned my;
      longint unsigned spd;
      longint unsigned coef;
      logic     [24:0] age_next;
      if (c.func == FUNC_LAUNCH) begin
         pt_px    = c.start_x;
         pt_py    = c.start_y;
         pt_vx    = c.start_vx;
         pt_vy    = c.start_vy;
         pt_life  = c.life_time;
         pt_age   = '0;
         pt_alive = 1'b1;
      end else if (pt_alive) begin
         vx = pt_vx;
         vy = pt_vy;
         mx = abs64(vx);
         my = abs64(vy);
         // the dying tick still integrates below
         if (pt_age > pt_life) begin
            pt_alive = 1'b0;
            pt_age   = '0;
         end
         age_next = pt_age + c.step_time;
         pt_age   = age_next[24] ? 24'hFF_FFFF : age_next[23:0];
         pt_px    = clamp_s32(longint'(pt_px) + step_offset(vx, c.step_time));
         pt_py    = clamp_s32(longint'(pt_py) + step_offset(vy, c.step_time));
         spd  = root_floor(mx * mx + my * my);
         coef = ({40'd0, drag_coef} * spd) >> 16;
         dx   = drag_term(coef, mx);
         dy   = drag_term(coef, my);
         pt_vx = clamp_s32(vx + ((vx < 0) ? dx : -dx));
         pt_vy = clamp_s32(vy + ((vy < 0) ? dy : -dy) + longint'(g_accel));
      end
      return '{pt_alive, pt_px, pt_py, pt_vx, pt_vy};
   endfunction

   // ------------------------------------------------------------------------
   // Random stimulus
   // ------------------------------------------------------------------------
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return CORNER_VALS[$urandom_range(0, 3)];
         2:       return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      endcase
   endfunction

   function automatic logic [15:0] rand_step();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 16'hFFFF);
         1:       return $urandom_range(0, 16'h0800);
         2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return $urandom_range(16'h0800, 16'h4000);
      endcase
   endfunction

   function automatic particle_cmd_type rand_cmd();
      particle_cmd_type c;
      c.func      = $urandom_range(0, 1);
      c.step_time = $urandom_range(0, 16'hFFFF);
      c.start_x   = $urandom;
      c.start_y   = $urandom;
      c.start_vx  = $urandom;
      c.start_vy  = $urandom;
      c.life_time = $urandom_range(0, 24'hFF_FFFF);
      return c;
   endfunction

   function automatic force_cfg_type phase_forces(input int p);
      force_cfg_type f;
      case (p)
         0: begin
            f.grav = 32'shFFF6_3333;
            f.fric = 24'h00_0200;
         end
         1: begin
            f.grav = 32'sh0000_0000;
            f.fric = 24'h00_0000;
         end
         2: begin
            f.grav = 32'sh7FFF_FFFF;
            f.fric = 24'hFF_FFFF;
         end
         3: begin
            f.grav = 32'sh8000_0000;
            f.fric = 24'h00_0000;
         end
         4: begin
            f.grav = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            f.fric = $urandom_range(0, 24'h00_0400);
         end
         5: begin
            f.grav = $urandom;
            f.fric = $urandom_range(0, 24'hFF_FFFF);
         end
         6: begin
            f.grav = -32'sh0000_1000;
            f.fric = 24'h00_0040;
         end
         default: begin
            f.grav = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            f.fric = $urandom_range(0, 24'h00_0080);
         end
      endcase
      return f;
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------
   task automatic send_cmd(input particle_cmd_type c, input bit typed,
                           input particle_state_type want);
      int unsigned gap;
      req_if.valid     <= 1'b1;
      req_if.func      <= c.func;
      req_if.step_time <= c.step_time;
      req_if.start_x   <= c.start_x;
      req_if.start_y   <= c.start_y;
      req_if.start_vx  <= c.start_vx;
      req_if.start_vy  <= c.start_vy;
      req_if.life_time <= c.life_time;
      cmd_typed        <= typed;
      cmd_want         <= want;
      do @(posedge clock); while (!req_if.ready);
      // bursts of items, with random gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      // let the monitor book the last item before looking at the queue
      @(posedge clock);
      while (states_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_forces(input force_cfg_type f);
      csr_if.valid <= 1'b1;
      csr_if.index <= CSR_GRAVITY;
      csr_if.data  <= f.grav;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.index <= CSR_AIR_FRICTION;
      csr_if.data  <= {8'd0, f.fric};
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic run_phase(input int quota, input bit age_run);
      int               sent_here;
      int               ticks;
      particle_cmd_type c;
      sent_here = 0;
      if (age_run) begin
         // drive the age into saturation, then one tick past the limit
         c = rand_cmd();
         c.func      = FUNC_LAUNCH;
         c.start_x   = rand_coord();
         c.start_y   = rand_coord();
         c.start_vx  = rand_coord();
         c.start_vy  = rand_coord();
         c.life_time = 24'hFF_FFFE;
         send_cmd(c, 1'b0, '0);
         repeat (258) begin
            c = rand_cmd();
            c.func      = FUNC_TICK;
            c.step_time = 16'hFFFF;
            send_cmd(c, 1'b0, '0);
         end
         sent_here += 259;
      end
      while (sent_here < quota) begin
         if ($urandom_range(0, 9) < 7) begin
            c = rand_cmd();
            c.func      = FUNC_LAUNCH;
            c.start_x   = rand_coord();
            c.start_y   = rand_coord();
            c.start_vx  = rand_coord();
            c.start_vy  = rand_coord();
            c.life_time = $urandom_range(0, 24'h08_0000);
            send_cmd(c, 1'b0, '0);
            ticks = $urandom_range(1, 14);
            repeat (ticks) begin
               c = rand_cmd();
               c.func      = FUNC_TICK;
               c.step_time = rand_step();
               send_cmd(c, 1'b0, '0);
            end
            sent_here += ticks + 1;
         end else begin
            send_cmd(rand_cmd(), 1'b0, '0);
            sent_here++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: stall pattern in one of three modes, redrawn at random
   // ------------------------------------------------------------------------
   int unsigned rx_cycle = 0;
   int unsigned rx_mode  = 0;
   int unsigned rx_run   = 0;
   bit          rx_hold  = 1'b0;

   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= $urandom_range(0, 1);
         default: begin
            if (rx_run == 0) begin
               rx_hold = ~rx_hold;
               rx_run  = rx_hold ? $urandom_range(1, 8) : $urandom_range(1, 30);
            end
            rsp_if.ready <= rx_hold;
            rx_run--;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Monitor: check results, book items and register writes, watchdog
   // ------------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      particle_state_type got;
      particle_state_type due;
      particle_cmd_type   c;
      bit                 moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            got = '{rsp_if.alive, rsp_if.pos_x, rsp_if.pos_y, rsp_if.vel_x, rsp_if.vel_y};
            if (states_due.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t ns: result with nothing outstanding, expected none, got %h",
                           $time, got);
            end else begin
               due = states_due.pop_front();
               compare_field("alive", {31'd0, due.alive}, {31'd0, got.alive});
               compare_field("pos_x", due.pos_x, got.pos_x);
               compare_field("pos_y", due.pos_y, got.pos_y);
               compare_field("vel_x", due.vel_x, got.vel_x);
               compare_field("vel_y", due.vel_y, got.vel_y);
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            moved = 1'b1;
            if (csr_if.index == CSR_GRAVITY) g_accel = csr_if.data;
            else drag_coef = csr_if.data[23:0];
         end
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            c = '{req_if.func, req_if.step_time, req_if.start_x, req_if.start_y,
                  req_if.start_vx, req_if.start_vy, req_if.life_time};
            due = step_particle(c);
            if (cmd_typed) due = cmd_want;
            states_due.push_back(due);
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.func      <= FUNC_TICK;
      req_if.step_time <= '0;
      req_if.start_x   <= '0;
      req_if.start_y   <= '0;
      req_if.start_vx  <= '0;
      req_if.start_vy  <= '0;
      req_if.life_time <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= CSR_GRAVITY;
      csr_if.data      <= '0;
      cmd_typed        <= 1'b0;
      cmd_want         <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].cfg >= 0) begin
            wait_for_results();
            set_forces(dir_forces[dir_rows[i].cfg]);
         end
         send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_for_results();
         set_forces(phase_forces(p));
         run_phase(RANDOM_ITEMS / PHASES, p == AGE_RUN_PHASE);
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
